// File: rtl/peq_pkg.sv
// Package: shared types, codes and tables of the pedal event queue qualifier.
`default_nettype none
package peq_pkg;

  localparam int unsigned STAMP_W = 32;
  localparam int unsigned CFG_W   = 16;
  localparam int unsigned ENTRY_W = 2 + STAMP_W + 1;

  localparam logic [CFG_W-1:0] DEBOUNCE_RST = 16'd800;
  localparam logic [CFG_W-1:0] RELEASE_RST  = 16'd2000;
  localparam logic [CFG_W-1:0] TIMEOUT_RST  = 16'd3000;

  typedef enum logic [1:0] {
    CFG_DEBOUNCE = 2'd0,
    CFG_RELEASE  = 2'd1,
    CFG_TIMEOUT  = 2'd2
  } cfg_idx_t;

  typedef enum logic [2:0] {
    ACT_NONE           = 3'd0,
    ACT_NOTE_ON        = 3'd1,
    ACT_KEY_PRESS      = 3'd2,
    ACT_KEY_RELEASE    = 3'd3,
    ACT_SILENT_RELEASE = 3'd4,
    ACT_FALSE_TRIGGER  = 3'd5
  } action_t;

  localparam logic MODE_EDGE = 1'b0;
  localparam logic MODE_TICK = 1'b1;

  typedef enum logic [2:0] {
    S_IDLE  = 3'b001,
    S_FETCH = 3'b010,
    S_EVAL  = 3'b100
  } state_t;

  typedef struct packed {
    logic capture;
    logic tick_inc;
    logic commit;
  } cmd_t;

  typedef struct packed {
    logic mode_tick;
    logic out_busy;
  } status_t;

  function automatic action_t press_action(input logic [1:0] p);
    action_t a;
    a = (p[1] == 1'b0) ? ACT_NOTE_ON : ACT_KEY_PRESS;
    return a;
  endfunction

  function automatic logic [6:0] press_code(input logic [1:0] p);
    logic [6:0] c;
    case (p)
      2'd0:    c = 7'd60;
      2'd1:    c = 7'd61;
      2'd2:    c = 7'h4F;
      default: c = 7'h50;
    endcase
    return c;
  endfunction

  function automatic logic [6:0] press_vel(input logic [1:0] p);
    logic [6:0] v;
    case (p)
      2'd0:    v = 7'd44;
      2'd1:    v = 7'd33;
      default: v = 7'd0;
    endcase
    return v;
  endfunction

endpackage
`default_nettype wire

// File: rtl/pedal_event_queue_qualifier_unit.sv
// Top level of the pedal event queue qualifier: controller plus datapath.
// Each request passes through capture, head fetch (the queue RAM has a
// registered read, and a tick request advances the 32-bit counter here) and
// evaluation, which writes one result into the output register. Evaluation
// waits while a previous result is still held on the output, so a stalled
// consumer holds the block. The queue is a ring of QUEUE_DEPTH entries that
// holds at most QUEUE_DEPTH-1 pending edges; only the head is evaluated per
// tick. Configuration writes take effect at once and are meant to be made
// while no request is in flight. No clearing pass is needed after reset.
`default_nettype none
module pedal_event_queue_qualifier_unit
  import peq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic        in_mode,
  input  wire logic [1:0]  in_pedal_id,
  input  wire logic [3:0]  in_pin_levels,
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic      [2:0]  out_action,
  output logic      [1:0]  out_pedal_no,
  output logic      [6:0]  out_code,
  output logic      [6:0]  out_velocity,
  output logic             out_led_on,
  output logic             out_queued,
  output logic      [3:0]  out_enable_mask,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_wdata
);

  cmd_t    cmd;
  status_t status;

  peq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .status  (status),
    .cmd     (cmd)
  );

  peq_dp #(
    .QUEUE_DEPTH(QUEUE_DEPTH)
  ) u_dp (
    .clk            (clk),
    .rst_n          (rst_n),
    .cmd            (cmd),
    .status         (status),
    .in_mode        (in_mode),
    .in_pedal_id    (in_pedal_id),
    .in_pin_levels  (in_pin_levels),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_wdata      (cfg_wdata),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_action     (out_action),
    .out_pedal_no   (out_pedal_no),
    .out_code       (out_code),
    .out_velocity   (out_velocity),
    .out_led_on     (out_led_on),
    .out_queued     (out_queued),
    .out_enable_mask(out_enable_mask)
  );

endmodule
`default_nettype wire

// File: rtl/peq_ram.sv
// Generic single-clock RAM: one write port, one read port with registered data.
`default_nettype none
module peq_ram #(
  parameter int unsigned WIDTH = 8,
  parameter int unsigned DEPTH = 8
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule
`default_nettype wire

// File: rtl/peq_ctrl.sv
// Controller: sequences capture, head fetch and evaluation of each request.
`default_nettype none
module peq_ctrl
  import peq_pkg::*;
(
  input  wire logic    clk,
  input  wire logic    rst_n,
  input  wire logic    in_valid,
  output logic         in_ready,
  input  wire status_t status,
  output cmd_t         cmd
);

  state_t state_r, state_nxt;

  assign in_ready     = (state_r == S_IDLE);
  assign cmd.capture  = in_valid && (state_r == S_IDLE);
  assign cmd.tick_inc = (state_r == S_FETCH) && status.mode_tick;
  assign cmd.commit   = (state_r == S_EVAL) && !status.out_busy;

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (in_valid) state_nxt = S_FETCH;
      end
      S_FETCH: begin
        state_nxt = S_EVAL;
      end
      S_EVAL: begin
        if (!status.out_busy) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule
`default_nettype wire

// File: rtl/peq_dp.sv
// Datapath: queue pointers, tick counter, enables, head evaluation and result register.
`default_nettype none
module peq_dp
  import peq_pkg::*;
#(
  parameter int unsigned QUEUE_DEPTH = 8
) (
  input  wire logic             clk,
  input  wire logic             rst_n,
  input  wire cmd_t             cmd,
  output status_t               status,
  input  wire logic             in_mode,
  input  wire logic [1:0]       in_pedal_id,
  input  wire logic [3:0]       in_pin_levels,
  input  wire logic             cfg_we,
  input  wire logic [1:0]       cfg_index,
  input  wire logic [CFG_W-1:0] cfg_wdata,
  output logic                  out_valid,
  input  wire logic             out_ready,
  output logic      [2:0]       out_action,
  output logic      [1:0]       out_pedal_no,
  output logic      [6:0]       out_code,
  output logic      [6:0]       out_velocity,
  output logic                  out_led_on,
  output logic                  out_queued,
  output logic      [3:0]       out_enable_mask
);

  localparam int unsigned PW = $clog2(QUEUE_DEPTH);
  localparam logic [PW-1:0] PTR_LAST = PW'(QUEUE_DEPTH - 1);

  function automatic logic [PW-1:0] ring_next(input logic [PW-1:0] p);
    return (p == PTR_LAST) ? '0 : p + 1'b1;
  endfunction

  logic             mode_r;
  logic [1:0]       pid_r;
  logic [3:0]       pins_r;
  logic [PW-1:0]    wr_ptr_r, wr_ptr_nxt;
  logic [PW-1:0]    rd_ptr_r, rd_ptr_nxt;
  logic [STAMP_W-1:0] tick_r;
  logic [3:0]       en_r, en_nxt;
  logic             led_r, led_nxt;
  logic [CFG_W-1:0] dbn_r, rel_r, tmo_r;
  logic             out_valid_r;
  action_t          act_nxt;
  logic [1:0]       pno_nxt;
  logic [6:0]       code_nxt, vel_nxt;
  logic             queued_nxt;

  logic               ram_we;
  logic [PW-1:0]      ram_waddr;
  logic [ENTRY_W-1:0] ram_wdata, ram_rdata;

  logic [1:0]         h_pedal;
  logic [STAMP_W-1:0] h_stamp;
  logic               h_pressed;
  logic [STAMP_W-1:0] elapsed;
  logic               pin_low, empty, full;

  peq_ram #(
    .WIDTH(ENTRY_W),
    .DEPTH(QUEUE_DEPTH)
  ) u_queue (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(rd_ptr_r),
    .rdata(ram_rdata)
  );

  assign {h_pedal, h_stamp, h_pressed} = ram_rdata;
  assign elapsed = tick_r - h_stamp;
  assign pin_low = !pins_r[h_pedal];
  assign empty   = (rd_ptr_r == wr_ptr_r);
  assign full    = (ring_next(wr_ptr_r) == rd_ptr_r);

  assign status.mode_tick = (mode_r == MODE_TICK);
  assign status.out_busy  = out_valid_r && !out_ready;

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    en_nxt     = en_r;
    led_nxt    = led_r;
    act_nxt    = ACT_NONE;
    pno_nxt    = 2'd0;
    code_nxt   = 7'd0;
    vel_nxt    = 7'd0;
    queued_nxt = 1'b0;
    ram_we     = 1'b0;
    ram_waddr  = wr_ptr_r;
    ram_wdata  = {pid_r, tick_r, 1'b0};
    if (mode_r == MODE_EDGE) begin
      if (en_r[pid_r]) begin
        en_nxt[pid_r] = 1'b0;
        if (!full) begin
          ram_we     = cmd.commit;
          wr_ptr_nxt = ring_next(wr_ptr_r);
          queued_nxt = 1'b1;
        end
      end
    end else if (!empty) begin
      if (!h_pressed && (elapsed > STAMP_W'(dbn_r)) && pin_low) begin
        ram_we    = cmd.commit;
        ram_waddr = rd_ptr_r;
        ram_wdata = {h_pedal, h_stamp, 1'b1};
        act_nxt   = press_action(h_pedal);
        pno_nxt   = h_pedal;
        code_nxt  = press_code(h_pedal);
        vel_nxt   = press_vel(h_pedal);
        led_nxt   = 1'b1;
      end else if (h_pressed && (elapsed > STAMP_W'(rel_r))) begin
        en_nxt[h_pedal] = 1'b1;
        act_nxt    = h_pedal[1] ? ACT_KEY_RELEASE : ACT_SILENT_RELEASE;
        pno_nxt    = h_pedal;
        rd_ptr_nxt = ring_next(rd_ptr_r);
        led_nxt    = 1'b0;
      end else if (!h_pressed && (elapsed > STAMP_W'(tmo_r))) begin
        en_nxt[h_pedal] = 1'b1;
        act_nxt    = ACT_FALSE_TRIGGER;
        pno_nxt    = h_pedal;
        rd_ptr_nxt = ring_next(rd_ptr_r);
        led_nxt    = 1'b0;
      end
    end
  end

  // captured request payload
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      mode_r <= in_mode;
      pid_r  <= in_pedal_id;
      pins_r <= in_pin_levels;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r    <= '0;
      rd_ptr_r    <= '0;
      tick_r      <= '0;
      en_r        <= 4'hF;
      led_r       <= 1'b0;
      dbn_r       <= DEBOUNCE_RST;
      rel_r       <= RELEASE_RST;
      tmo_r       <= TIMEOUT_RST;
      out_valid_r <= 1'b0;
    end else begin
      if (cmd.tick_inc) begin
        tick_r <= tick_r + 1'b1;
      end
      if (cmd.commit) begin
        wr_ptr_r <= wr_ptr_nxt;
        rd_ptr_r <= rd_ptr_nxt;
        en_r     <= en_nxt;
        led_r    <= led_nxt;
      end
      if (cfg_we) begin
        case (cfg_index)
          CFG_DEBOUNCE: dbn_r <= cfg_wdata;
          CFG_RELEASE:  rel_r <= cfg_wdata;
          CFG_TIMEOUT:  tmo_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (cmd.commit) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.commit) begin
      out_action      <= act_nxt;
      out_pedal_no    <= pno_nxt;
      out_code        <= code_nxt;
      out_velocity    <= vel_nxt;
      out_led_on      <= led_nxt;
      out_queued      <= queued_nxt;
      out_enable_mask <= en_nxt;
    end
  end

  assign out_valid = out_valid_r;

endmodule
`default_nettype wire

// File: sim/pedal_event_queue_qualifier_unit_tb.sv
// Testbench for the pedal event queue qualifier: directed and random requests, self-checked.
`timescale 1ns / 100ps
`default_nettype none
module pedal_event_queue_qualifier_unit_tb;
  import peq_pkg::*;

  localparam int unsigned RING_SLOTS     = 8;
  localparam int unsigned IDLE_PCT       = 8;
  localparam int unsigned SETTLE_CYCLES  = 6;
  localparam int unsigned WATCHDOG_LIMIT = 3000;
  localparam int unsigned STALL_CYCLES   = 300;
  localparam int unsigned RANDOM_TARGET  = 840;
  localparam int unsigned PRINT_CAP      = 40;

  localparam logic [1:0] CFG_SPARE   = 2'd3;
  localparam logic [3:0] PINS_ALL_UP = 4'hF;
  localparam logic [3:0] PINS_ALL_DN = 4'h0;

  localparam logic [6:0] NOTE_PEDAL0 = 7'd60;
  localparam logic [6:0] NOTE_PEDAL1 = 7'd61;
  localparam logic [6:0] KEY_PEDAL2  = 7'h4F;
  localparam logic [6:0] KEY_PEDAL3  = 7'h50;
  localparam logic [6:0] VEL_PEDAL0  = 7'd44;
  localparam logic [6:0] VEL_PEDAL1  = 7'd33;

  localparam int unsigned PINS_UNIFORM = 0;
  localparam int unsigned PINS_MOSTLY_DN = 1;
  localparam int unsigned PINS_MOSTLY_UP = 2;

  typedef struct packed {
    action_t    action;
    logic [1:0] pedal_no;
    logic [6:0] code;
    logic [6:0] velocity;
    logic       led_on;
    logic       queued;
    logic [3:0] enable_mask;
  } pedal_result_t;

  logic        clk;
  logic        rst_n = 1'b0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_mode = MODE_EDGE;
  logic [1:0]  in_pedal_id = 2'd0;
  logic [3:0]  in_pin_levels = PINS_ALL_UP;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [2:0]  out_action;
  logic [1:0]  out_pedal_no;
  logic [6:0]  out_code;
  logic [6:0]  out_velocity;
  logic        out_led_on;
  logic        out_queued;
  logic [3:0]  out_enable_mask;
  logic        cfg_we = 1'b0;
  logic [1:0]  cfg_index = 2'd0;
  logic [15:0] cfg_wdata = 16'd0;

  // predicted block state
  logic [1:0]  ring_pedal   [RING_SLOTS];
  logic [31:0] ring_stamp   [RING_SLOTS];
  logic        ring_pressed [RING_SLOTS];
  int unsigned ring_wr = 0;
  int unsigned ring_rd = 0;
  logic [31:0] tick_now = 32'd0;
  logic [3:0]  pedal_armed = 4'hF;
  logic        lamp = 1'b0;
  logic [15:0] debounce_lim = DEBOUNCE_RST;
  logic [15:0] release_lim = RELEASE_RST;
  logic [15:0] timeout_lim = TIMEOUT_RST;

  pedal_result_t pending_results[$];

  bit          steady_flow = 1'b0;
  int unsigned out_hold_cycles = 0;
  int unsigned mismatches = 0;
  int unsigned results_checked = 0;
  int unsigned requests_sent = 0;
  int unsigned effective_requests = 0;
  int unsigned edges_queued = 0;
  int unsigned edges_ignored = 0;
  int unsigned presses_seen = 0;
  int unsigned releases_seen = 0;
  int unsigned false_drops = 0;

  pedal_event_queue_qualifier_unit dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_mode         (in_mode),
    .in_pedal_id     (in_pedal_id),
    .in_pin_levels   (in_pin_levels),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_action      (out_action),
    .out_pedal_no    (out_pedal_no),
    .out_code        (out_code),
    .out_velocity    (out_velocity),
    .out_led_on      (out_led_on),
    .out_queued      (out_queued),
    .out_enable_mask (out_enable_mask),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_wdata       (cfg_wdata)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic pedal_result_t qualify_request(input logic mode, input logic [1:0] pid,
                                                    input logic [3:0] pins);
    pedal_result_t r;
    int unsigned   nxt;
    logic [1:0]    hp;
    logic [31:0]   age;
    r = '0;
    r.action = ACT_NONE;
    if (mode == MODE_EDGE) begin
      if (pedal_armed[pid]) begin
        nxt = (ring_wr + 1) % RING_SLOTS;
        pedal_armed[pid] = 1'b0;
        if (nxt != ring_rd) begin
          ring_pedal[ring_wr]   = pid;
          ring_stamp[ring_wr]   = tick_now;
          ring_pressed[ring_wr] = 1'b0;
          ring_wr  = nxt;
          r.queued = 1'b1;
        end
      end
    end else begin
      tick_now = tick_now + 32'd1;
      if (ring_rd != ring_wr) begin
        hp  = ring_pedal[ring_rd];
        age = tick_now - ring_stamp[ring_rd];
        if (!ring_pressed[ring_rd] && age > {16'd0, debounce_lim} && !pins[hp]) begin
          ring_pressed[ring_rd] = 1'b1;
          r.pedal_no = hp;
          lamp = 1'b1;
          case (hp)
            2'd0: begin
              r.action = ACT_NOTE_ON;
              r.code = NOTE_PEDAL0;
              r.velocity = VEL_PEDAL0;
            end
            2'd1: begin
              r.action = ACT_NOTE_ON;
              r.code = NOTE_PEDAL1;
              r.velocity = VEL_PEDAL1;
            end
            2'd2: begin
              r.action = ACT_KEY_PRESS;
              r.code = KEY_PEDAL2;
            end
            default: begin
              r.action = ACT_KEY_PRESS;
              r.code = KEY_PEDAL3;
            end
          endcase
        end else if (ring_pressed[ring_rd] && age > {16'd0, release_lim}) begin
          pedal_armed[hp] = 1'b1;
          r.action = hp[1] ? ACT_KEY_RELEASE : ACT_SILENT_RELEASE;
          r.pedal_no = hp;
          ring_rd = (ring_rd + 1) % RING_SLOTS;
          lamp = 1'b0;
        end else if (!ring_pressed[ring_rd] && age > {16'd0, timeout_lim}) begin
          pedal_armed[hp] = 1'b1;
          r.action = ACT_FALSE_TRIGGER;
          r.pedal_no = hp;
          ring_rd = (ring_rd + 1) % RING_SLOTS;
          lamp = 1'b0;
        end
      end
    end
    r.led_on = lamp;
    r.enable_mask = pedal_armed;
    return r;
  endfunction

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    mismatches++;
    if (mismatches <= PRINT_CAP)
      $display("MISMATCH @%0t result %0d %s: got %0h want %0h",
               $time, results_checked, what, got, want);
  endtask

  task automatic send_request(input logic mode, input logic [1:0] pid, input logic [3:0] pins);
    pedal_result_t want;
    int unsigned   gap;
    bit            ignored;
    @(negedge clk);
    if (!steady_flow && $urandom_range(0, 99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      gap = $urandom_range(1, 4);
      repeat (gap) @(negedge clk);
    end
    in_valid      <= 1'b1;
    in_mode       <= mode;
    in_pedal_id   <= pid;
    in_pin_levels <= pins;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    ignored = (mode == MODE_EDGE) && !pedal_armed[pid];
    want = qualify_request(mode, pid, pins);
    pending_results.push_back(want);
    requests_sent++;
    if (!ignored) effective_requests++;
    if (ignored) edges_ignored++;
    if (want.queued) edges_queued++;
    case (want.action)
      ACT_NOTE_ON, ACT_KEY_PRESS:             presses_seen++;
      ACT_KEY_RELEASE, ACT_SILENT_RELEASE:    releases_seen++;
      ACT_FALSE_TRIGGER:                      false_drops++;
      default: ;
    endcase
  endtask

  task automatic send_random(input int unsigned pin_style);
    logic       mode;
    logic [3:0] pins;
    mode = ($urandom_range(0, 99) < 30) ? MODE_EDGE : MODE_TICK;
    case (pin_style)
      PINS_MOSTLY_DN: pins = 4'($urandom & $urandom);
      PINS_MOSTLY_UP: pins = 4'($urandom | $urandom);
      default:        pins = 4'($urandom_range(0, 15));
    endcase
    send_request(mode, 2'($urandom_range(0, 3)), pins);
  endtask

  task automatic wait_for_drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(negedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    case (idx)
      CFG_DEBOUNCE: debounce_lim = val;
      CFG_RELEASE:  release_lim = val;
      CFG_TIMEOUT:  timeout_lim = val;
      default: ;
    endcase
  endtask

  task automatic set_timing(input logic [15:0] deb, input logic [15:0] rel,
                            input logic [15:0] tmo);
    write_reg(CFG_DEBOUNCE, deb);
    write_reg(CFG_RELEASE, rel);
    write_reg(CFG_TIMEOUT, tmo);
  endtask

  // all pedals queue at tick 0; the reset timing is far too long to fire
  task automatic test_reset_state();
    send_request(MODE_EDGE, 2'd0, PINS_ALL_DN);
    send_request(MODE_EDGE, 2'd1, PINS_ALL_UP);
    send_request(MODE_EDGE, 2'd2, 4'hA);
    send_request(MODE_EDGE, 2'd3, 4'h5);
    send_request(MODE_EDGE, 2'd2, PINS_ALL_DN);
    repeat (5) send_request(MODE_TICK, 2'd3, PINS_ALL_DN);
    wait_for_drain();
  endtask

  // false trigger, press winning over timeout, note and key press/release
  task automatic test_qualify_sequence();
    set_timing(16'd2, 16'd6, 16'd4);
    send_request(MODE_TICK, 2'd0, PINS_ALL_UP);
    repeat (6) send_request(MODE_TICK, 2'd1, PINS_ALL_DN);
    send_request(MODE_EDGE, 2'd0, PINS_ALL_UP);
    send_request(MODE_TICK, 2'd2, 4'hE);
    send_request(MODE_TICK, 2'd2, 4'hE);
    repeat (5) send_request(MODE_TICK, 2'd0, 4'h6);
    send_request(MODE_TICK, 2'd0, PINS_ALL_DN);
    wait_for_drain();
  endtask

  task automatic test_register_extremes();
    write_reg(CFG_SPARE, 16'hFFFF);
    repeat (8) send_random(PINS_UNIFORM);
    wait_for_drain();
    set_timing(16'd0, 16'd0, 16'd0);
    repeat (16) send_random(PINS_UNIFORM);
    wait_for_drain();
    set_timing(16'hFFFF, 16'hFFFF, 16'hFFFF);
    repeat (10) send_random(PINS_MOSTLY_DN);
    wait_for_drain();
    set_timing(16'd0, 16'hFFFF, 16'hFFFF);
    repeat (10) send_random(PINS_MOSTLY_DN);
    wait_for_drain();
    set_timing(16'hFFFF, 16'd0, 16'd0);
    repeat (10) send_random(PINS_UNIFORM);
    wait_for_drain();
  endtask

  task automatic test_output_stall();
    set_timing(16'd1, 16'd4, 16'd3);
    out_hold_cycles = STALL_CYCLES;
    repeat (40) send_random(PINS_MOSTLY_DN);
    wait_for_drain();
  endtask

  task automatic test_random_traffic();
    int unsigned phase;
    int unsigned goal;
    phase = 0;
    goal = requests_sent + RANDOM_TARGET;
    while (requests_sent < goal) begin
      steady_flow = (phase == 3);
      if (phase % 4 == 2)
        set_timing(16'($urandom_range(10, 40)), 16'($urandom_range(20, 80)),
                   16'($urandom_range(10, 60)));
      else
        set_timing(16'($urandom_range(0, 6)), 16'($urandom_range(0, 14)),
                   16'($urandom_range(0, 14)));
      repeat (120) send_random((phase % 5 == 4) ? PINS_MOSTLY_UP :
                               (phase % 5 == 1) ? PINS_UNIFORM : PINS_MOSTLY_DN);
      wait_for_drain();
      phase++;
    end
    steady_flow = 1'b0;
  endtask

  always @(negedge clk) begin
    if (out_hold_cycles > 0) begin
      out_hold_cycles--;
      out_ready <= 1'b0;
    end else begin
      out_ready <= steady_flow || ($urandom_range(0, 99) >= IDLE_PCT);
    end
  end

  always @(posedge clk) begin : result_check
    pedal_result_t want;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("unexpected result", 32'd1, 32'd0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (out_action !== want.action)
          report_mismatch("action", 32'(out_action), 32'(want.action));
        if (out_pedal_no !== want.pedal_no)
          report_mismatch("pedal_no", 32'(out_pedal_no), 32'(want.pedal_no));
        if (out_code !== want.code)
          report_mismatch("code", 32'(out_code), 32'(want.code));
        if (out_velocity !== want.velocity)
          report_mismatch("velocity", 32'(out_velocity), 32'(want.velocity));
        if (out_led_on !== want.led_on)
          report_mismatch("led_on", 32'(out_led_on), 32'(want.led_on));
        if (out_queued !== want.queued)
          report_mismatch("queued", 32'(out_queued), 32'(want.queued));
        if (out_enable_mask !== want.enable_mask)
          report_mismatch("enable_mask", 32'(out_enable_mask), 32'(want.enable_mask));
        results_checked++;
      end
    end
  end

  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < WATCHDOG_LIMIT) begin
      @(posedge clk);
      if ((in_valid && in_ready) || (out_valid && out_ready)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no request moved for %0d cycles", WATCHDOG_LIMIT);
    $display("end of test: mismatches");
    $finish;
  end

  initial begin : main_sequence
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_qualify_sequence();
    test_register_extremes();
    test_output_stall();
    test_random_traffic();
    wait_for_drain();
    if (pending_results.size() != 0)
      report_mismatch("results never produced", 32'd0, 32'(pending_results.size()));
    $display("covered %0d requests (%0d effective): %0d edges queued, %0d ignored",
             requests_sent, effective_requests, edges_queued, edges_ignored);
    $display("%0d presses, %0d releases, %0d false triggers; %0d results checked",
             presses_seen, releases_seen, false_drops, results_checked);
    if (mismatches == 0) begin
      $display("end of test: clean");
    end else begin
      $display("end of test: mismatches");
    end
    $finish;
  end

endmodule
`default_nettype wire

// File: files.f
rtl/peq_pkg.sv
rtl/peq_ram.sv
rtl/peq_ctrl.sv
rtl/peq_dp.sv
rtl/pedal_event_queue_qualifier_unit.sv
sim/pedal_event_queue_qualifier_unit_tb.sv
